/* src/chd_pkg.sv */
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and the pitch band factor tables.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int FFT_POINTS_DEF  = 1024;
    localparam int MAX_OCTAVES_DEF = 8;

    localparam int PITCHES   = 12;
    localparam int PWR_W     = 32;
    localparam int CHROMA_W  = 48;
    localparam int SCORE_W   = CHROMA_W + 2;
    localparam int TOTAL_W   = CHROMA_W + 4;
    localparam int FAC_W     = 31;
    localparam int BASE_W    = 32;
    localparam int PROD_W    = BASE_W + FAC_W;
    localparam int EDGE_SHIFT = 46;

    localparam logic [63:0] Q_DOWN = 64'd1043174479;
    localparam logic [63:0] Q_UP   = 64'd1105204861;
    localparam logic [63:0] Q_SEMI = 64'd1137589835;

    localparam logic [3:0]  OCT_RESET  = 4'd4;
    localparam logic [31:0] BASE_RESET = 32'd398124;

    localparam logic [1:0] CFG_OCTAVES = 2'd0;
    localparam logic [1:0] CFG_BASE    = 2'd1;

    typedef logic [FAC_W-1:0] t_fac;
    typedef t_fac t_fac_tab [PITCHES];

    typedef enum logic [3:0] {
        S_LOAD, S_WAIT, S_OCT, S_MUL_LO, S_SH_LO, S_MUL_HI, S_SH_HI,
        S_RD, S_DRAIN, S_DIV_GO, S_DIV_WAIT, S_WRITE, S_SC_INIT, S_SCORE, S_FIN
    } t_state;

    function automatic t_fac_tab make_fac(logic [63:0] start);
        t_fac_tab    tab;
        logic [63:0] f;
        f = start;
        for (int p = 0; p < PITCHES; p++) begin
            tab[p] = f[FAC_W-1:0];
            f = (f * Q_SEMI + 64'd536870912) >> 30;
        end
        return tab;
    endfunction

    localparam t_fac_tab FAC_LO = make_fac(Q_DOWN);
    localparam t_fac_tab FAC_HI = make_fac(Q_UP);

    // Offset of triad member k above the root.
    function automatic logic [3:0] triad_off(logic minor, logic [1:0] k);
        logic [3:0] o;
        case (k)
            2'd1:    o = minor ? 4'd3 : 4'd4;
            2'd2:    o = 4'd7;
            default: o = 4'd0;
        endcase
        return o;
    endfunction

endpackage

/* src/chd_power.sv */
// ----------------------------------------------------------------------------
// chd_power
// Bin power pipeline and power store for the lower half of the frame.
// ----------------------------------------------------------------------------
module chd_power #(
    parameter int FFT_POINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [15:0] i_re,
    input  logic [15:0] i_im,
    input  logic        i_last,
    input  logic [$clog2(FFT_POINTS/2)-1:0] i_rd_addr,
    output logic [31:0] o_rd_data,
    output logic        o_done
);
    import chd_pkg::*;

    localparam int HALF = FFT_POINTS / 2;
    localparam int AW   = $clog2(HALF);

    logic [PWR_W-1:0] mem [HALF];
    logic [AW:0]      r_bin;
    logic             r1_vld, r1_last, r1_wr;
    logic [AW-1:0]    r1_addr;
    logic [31:0]      r1_sq_re, r1_sq_im;
    logic             r_done;
    logic [31:0]      r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin   <= '0;
            r1_vld  <= 1'b0;
            r1_last <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r1_vld  <= i_accept;
            r1_last <= i_accept && i_last;
            r_done  <= r1_vld && r1_last;
            if (i_accept) begin
                if (i_last) begin
                    r_bin <= '0;
                end else if (r_bin < (AW+1)'(HALF)) begin
                    r_bin <= r_bin + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r1_sq_re <= 32'($signed(i_re)) * 32'($signed(i_re));
            r1_sq_im <= 32'($signed(i_im)) * 32'($signed(i_im));
            r1_addr  <= r_bin[AW-1:0];
            r1_wr    <= r_bin < (AW+1)'(HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_vld && r1_wr) begin
            mem[r1_addr] <= r1_sq_re + r1_sq_im;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_done    = r_done;

endmodule

/* src/chd_div.sv */
// ----------------------------------------------------------------------------
// chd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module chd_div #(
    parameter int DW  = 41,
    parameter int DVW = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_done,
    output logic [DW-1:0]  o_quotient
);
    import chd_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DVW-1:0]   r_rem, r_div;
    logic [DW-1:0]    r_quo;
    logic [DVW:0]     rem_sh, rem_sub;

    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_div}) begin
                r_rem <= rem_sub[DVW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DVW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/chroma_chord_detector.sv */
// ----------------------------------------------------------------------------
// chroma_chord_detector
// Triad recognition from one frame of complex FFT bins.
// ----------------------------------------------------------------------------
// Usage:
//   s-side: one complex bin per item, tdata = {imag, real}, tlast ends frame.
//   Bins are taken one per cycle while loading; the power of the first
//   FFT_POINTS/2 bins is kept in the power store.
//   After tlast the block stops taking bins and analyzes the frame: per pitch
//   and octave two band edge multiplies, one store read per band bin and a
//   bit-serial divide form the band mean; then the 24 triads are scored.
//   Frame analysis time is set by the single store read port and the
//   shared divider.
//   m-side: one item per frame; held in an output register until taken, so
//   loading of the next frame proceeds while it waits. A second result waits
//   for the first to be taken.
//   cfg: index 0 octave count, index 1 middle C bin (Q16.16). Write only
//   while idle. Reset restores defaults and starts in the loading phase.
// ----------------------------------------------------------------------------
module chroma_chord_detector #(
    parameter int FFT_POINTS  = chd_pkg::FFT_POINTS_DEF,
    parameter int MAX_OCTAVES = chd_pkg::MAX_OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] bin_real, [31:16] bin_imag
    input  logic        s_tlast,   // last_bin
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [3:0] chord_root, [51:4] best_score
    output logic [1:0]  m_tuser,   // [0] chord_found, [1] chord_minor
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import chd_pkg::*;

    localparam int HALF  = FFT_POINTS / 2;
    localparam int AW    = $clog2(HALF);
    localparam int SUM_W = PWR_W + AW;

    t_state r_state, n_state;

    logic [3:0]        r_oct_cnt;
    logic [31:0]       r_base;
    logic [3:0]        octs;
    logic [3:0]        r_p, r_r;
    logic [1:0]        r_k;
    logic              r_m;
    logic [PROD_W-1:0] r_prod;
    logic [AW-1:0]     r_lo, r_hi, r_j, edge_v;
    logic [SUM_W-1:0]  r_sum;
    logic              r_rd_vld;
    logic [CHROMA_W-1:0] r_acc;
    logic [CHROMA_W-1:0] r_chroma [PITCHES];
    logic [TOTAL_W-1:0]  r_total;
    logic [SCORE_W-1:0]  r_s, r_best, s_next;
    logic [3:0]        r_best_root;
    logic              r_best_minor;
    logic [4:0]        idx5;
    logic [3:0]        idx;
    logic [PROD_W-1:0] shifted;
    logic [5:0]        shamt;
    logic              accept, div_start, div_done, pwr_done, found;
    logic [SUM_W-1:0]  quo;
    logic [31:0]       rd_data;
    logic              r_out_vld, r_out_found, r_out_minor;
    logic [3:0]        r_out_root;
    logic [CHROMA_W-1:0] r_out_score;

    assign accept = s_tvalid && s_tready;
    assign octs   = (r_oct_cnt > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : r_oct_cnt;

    chd_power #(.FFT_POINTS(FFT_POINTS)) u_power (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_re      (s_tdata[15:0]),
        .i_im      (s_tdata[31:16]),
        .i_last    (s_tlast),
        .i_rd_addr (r_j),
        .o_rd_data (rd_data),
        .o_done    (pwr_done)
    );

    chd_div #(.DW(SUM_W), .DVW(AW + 1)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  ({1'b0, r_hi} - {1'b0, r_lo} + 1'b1),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // band edge: product >> (46 - octave), saturated to the store
    assign shamt   = 6'(EDGE_SHIFT) - {2'b00, r_r};
    assign shifted = r_prod >> shamt;
    assign edge_v  = (shifted > PROD_W'(HALF - 1)) ? AW'(HALF - 1) : shifted[AW-1:0];

    assign idx5   = {1'b0, r_p} + {1'b0, triad_off(r_m, r_k)};
    assign idx    = (idx5 >= 5'd12) ? 4'(idx5 - 5'd12) : idx5[3:0];
    assign s_next = r_s + SCORE_W'(r_chroma[idx]);
    assign found  = {r_best, 2'b00} > r_total;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:     if (accept && s_tlast) n_state = S_WAIT;
            S_WAIT:     if (pwr_done) n_state = S_OCT;
            S_OCT:      n_state = (r_r == octs) ? S_WRITE : S_MUL_LO;
            S_MUL_LO:   n_state = S_SH_LO;
            S_SH_LO:    n_state = S_MUL_HI;
            S_MUL_HI:   n_state = S_SH_HI;
            S_SH_HI:    n_state = S_RD;
            S_RD:       if (r_j == r_hi) n_state = S_DRAIN;
            S_DRAIN:    n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) n_state = S_OCT;
            S_WRITE:    n_state = (r_p == 4'd11) ? S_SC_INIT : S_OCT;
            S_SC_INIT:  n_state = S_SCORE;
            S_SCORE:    if (r_k == 2'd2 && r_p == 4'd11 && r_m) n_state = S_FIN;
            S_FIN:      if (!r_out_vld || m_tready) n_state = S_LOAD;
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_LOAD:   s_tready  = 1'b1;
            S_DIV_GO: div_start = 1'b1;
            default: begin
                s_tready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_oct_cnt <= OCT_RESET;
            r_base    <= BASE_RESET;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_RD);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OCTAVES: r_oct_cnt <= i_cfg_data[3:0];
                    CFG_BASE:    r_base    <= i_cfg_data;
                    default:     ;
                endcase
            end
            if (m_tvalid && m_tready) r_out_vld <= 1'b0;
            if (r_state == S_FIN && (!r_out_vld || m_tready)) r_out_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) r_sum <= r_sum + SUM_W'(rd_data);
        case (r_state)
            S_WAIT: begin
                r_p     <= '0;
                r_r     <= '0;
                r_acc   <= '0;
                r_total <= '0;
            end
            S_MUL_LO: begin
                r_prod <= PROD_W'(r_base) * PROD_W'(FAC_LO[r_p]);
                r_sum  <= '0;
            end
            S_SH_LO:  r_lo <= edge_v;
            S_MUL_HI: r_prod <= PROD_W'(r_base) * PROD_W'(FAC_HI[r_p]);
            S_SH_HI: begin
                r_hi <= edge_v;
                r_j  <= r_lo;
            end
            S_RD:     if (r_j != r_hi) r_j <= r_j + 1'b1;
            S_DIV_WAIT: begin
                if (div_done) begin
                    r_acc <= r_acc + CHROMA_W'(quo);
                    r_r   <= r_r + 1'b1;
                end
            end
            S_WRITE: begin
                r_chroma[r_p] <= r_acc;
                r_total       <= r_total + TOTAL_W'(r_acc);
                r_acc         <= '0;
                r_r           <= '0;
                r_p           <= r_p + 1'b1;
            end
            S_SC_INIT: begin
                r_p <= '0;
                r_m <= 1'b0;
                r_k <= '0;
                r_s <= '0;
            end
            S_SCORE: begin
                if (r_k == 2'd2) begin
                    r_k <= '0;
                    r_s <= '0;
                    if ((!r_m && r_p == 4'd0) || s_next > r_best) begin
                        r_best       <= s_next;
                        r_best_root  <= r_p;
                        r_best_minor <= r_m;
                    end
                    if (r_p == 4'd11) begin
                        r_p <= '0;
                        r_m <= 1'b1;
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                    r_s <= s_next;
                end
            end
            S_FIN: begin
                if (!r_out_vld || m_tready) begin
                    r_out_found <= found;
                    r_out_root  <= found ? r_best_root : 4'd0;
                    r_out_minor <= found && r_best_minor;
                    r_out_score <= r_best[CHROMA_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_out_vld;
    assign m_tdata     = {4'b0000, r_out_score, r_out_root};
    assign m_tuser     = {r_out_minor, r_out_found};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for chroma_chord_detector. A full first frame fills the
// power store, then short frames run under several octave and base settings
// with bursty bins and a stalling result side; each chord item is checked
// against an in-bench model of the chroma and triad scoring.
// ----------------------------------------------------------------------------
module testbench;
    import chd_pkg::*;

    localparam int HALF  = FFT_POINTS_DEF / 2;
    localparam int LIMIT = 20000000;

    typedef struct {
        bit        found;
        bit [3:0]  root;
        bit        minor;
        bit [47:0] score;
    } t_chord;

    class t_chord_scoreboard;
        bit [31:0] power_mem [HALF];
        bit [63:0] chroma [PITCHES];
        int        bin_pos;
        bit [3:0]  octaves;
        bit [31:0] base_bin;
        t_chord    pending_q [$];
        int        errors;

        function new();
            bin_pos  = 0;
            octaves  = OCT_RESET;
            base_bin = BASE_RESET;
            errors   = 0;
        endfunction

        function void set_reg(bit [1:0] idx, bit [31:0] val);
            if (idx == CFG_OCTAVES) octaves = val[3:0];
            else if (idx == CFG_BASE) base_bin = val;
        endfunction

        function bit [8:0] edge_bin(bit [63:0] fac, int octv);
            bit [63:0] e;
            e = ({32'd0, base_bin} * fac) >> (EDGE_SHIFT - octv);
            return (e > HALF - 1) ? 9'(HALF - 1) : e[8:0];
        endfunction

        function void build_chroma();
            bit [63:0] lo_f, hi_f, acc;
            int        octs, lo, hi;
            lo_f = Q_DOWN;
            hi_f = Q_UP;
            octs = (octaves > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : octaves;
            for (int p = 0; p < PITCHES; p++) begin
                chroma[p] = 0;
                for (int r = 0; r < octs; r++) begin
                    lo  = edge_bin(lo_f, r);
                    hi  = edge_bin(hi_f, r);
                    acc = 0;
                    for (int j = lo; j <= hi; j++) acc += power_mem[j];
                    chroma[p] += acc / (hi - lo + 1);
                end
                chroma[p] &= 64'hFFFF_FFFF_FFFF;
                lo_f = (lo_f * Q_SEMI + 64'd536870912) >> 30;
                hi_f = (hi_f * Q_SEMI + 64'd536870912) >> 30;
            end
        endfunction

        function void note_bin(bit signed [15:0] re, bit signed [15:0] im, bit last);
            longint    pw;
            bit [63:0] best, total, s;
            int        best_i, off;
            t_chord    c;
            pw = longint'(re) * re + longint'(im) * im;
            if (bin_pos < HALF) begin
                power_mem[bin_pos] = pw[31:0];
                bin_pos++;
            end
            if (!last) return;
            bin_pos = 0;
            build_chroma();
            best   = 0;
            best_i = 0;
            total  = 0;
            for (int m = 0; m < 2; m++) begin
                for (int p = 0; p < PITCHES; p++) begin
                    off = (m == 1) ? 3 : 4;
                    s = chroma[p] + chroma[(p + off) % 12] + chroma[(p + 7) % 12];
                    if ((m == 0 && p == 0) || s > best) begin
                        best   = s;
                        best_i = m * 12 + p;
                    end
                end
            end
            for (int p = 0; p < PITCHES; p++) total += chroma[p];
            c.found = (4 * best > total);
            c.root  = c.found ? 4'(best_i % 12) : 4'd0;
            c.minor = c.found ? (best_i >= 12) : 1'b0;
            c.score = best[47:0];
            pending_q.push_back(c);
        endfunction

        function void check_chord(bit found, bit [3:0] root, bit minor, bit [47:0] score);
            t_chord c;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected chord item found=%0b root=%0d minor=%0b score=%0d",
                         $time, found, root, minor, score);
                errors++;
                return;
            end
            c = pending_q.pop_front();
            if (found !== c.found) begin
                $display("%0t: chord_found exp %0b act %0b", $time, c.found, found);
                errors++;
            end
            if (root !== c.root) begin
                $display("%0t: chord_root exp %0d act %0d", $time, c.root, root);
                errors++;
            end
            if (minor !== c.minor) begin
                $display("%0t: chord_minor exp %0b act %0b", $time, c.minor, minor);
                errors++;
            end
            if (score !== c.score) begin
                $display("%0t: best_score exp %0d act %0d", $time, c.score, score);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_chord_scoreboard chords;
    int                cycles;
    int                burst_left;
    int                rx_mode;

    chroma_chord_detector uut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            chords.check_chord(m_tuser[0], m_tdata[3:0], m_tuser[1], m_tdata[51:4]);
    end

    always @(negedge i_clk) begin
        if (cycles % 300 == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_bin(bit [15:0] re, bit [15:0] im, bit last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        chords.note_bin(re, im, last);
    endtask

    function automatic bit [15:0] pick_val();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(int len);
        for (int i = 0; i < len; i++)
            send_bin(pick_val(), pick_val(), i == len - 1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (chords.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        chords.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        bit [3:0]  oct_tab  [8];
        bit [31:0] base_tab [8];
        oct_tab     = '{4'd4, 4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd5, 4'd8};
        chords      = new();
        cycles      = 0;
        burst_left  = 0;
        rx_mode     = 0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        base_tab = '{BASE_RESET, 32'd0, 32'hFFFF_FFFF, BASE_RESET, 32'd200000,
                     32'($urandom), 32'($urandom_range(0, 1200000)), BASE_RESET};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // full frame first so no band can read an unwritten store entry
        send_bin(16'h8000, 16'h8000, 1'b0);
        send_bin(16'h7FFF, 16'h7FFF, 1'b0);
        send_bin(16'h0000, 16'h0000, 1'b0);
        send_bin(16'h8000, 16'h7FFF, 1'b0);
        send_frame(520);
        drain();

        send_bin(16'h0000, 16'h0000, 1'b1);
        send_bin(16'h8000, 16'h8000, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_OCTAVES, {28'd0, oct_tab[ph]});
            write_reg(CFG_BASE, base_tab[ph]);
            for (int f = 0; f < 4; f++)
                send_frame($urandom_range(0, 4) == 0 ? $urandom_range(9, 30)
                                                     : $urandom_range(1, 8));
            drain();
        end

        if (chords.errors == 0 && chords.pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
